// ===== rtl/core/f2h_pkg.sv =====
// ----------------------------------------------------------------------------
// f2h_pkg: shared constants and types for the binary32 to 20-bit float converter.
// Holds the exponent thresholds and the result format fields.
// ----------------------------------------------------------------------------
package f2h_pkg;

    localparam int unsigned IN_W   = 32;
    localparam int unsigned OUT_W  = 20;

    localparam logic [7:0]  EXP_FLUSH_BELOW = 8'd84;
    localparam logic [7:0]  EXP_SAT_FROM    = 8'd159;
    localparam logic [7:0]  EXP_NORMAL_FROM = 8'd97;
    localparam logic [7:0]  EXP_OFFSET      = 8'd96;
    localparam logic [5:0]  OUT_EXP_MAX     = 6'b111110;
    localparam logic [12:0] OUT_MANT_ONES   = 13'b1111111111111;
    localparam logic [18:0] MAG_LIMIT       = 19'd516096; // exponent 63, mantissa 0

    typedef struct packed {
        logic [OUT_W-1:0] half20_bits;
        logic             overflowed;
        logic             underflowed;
    } result_t;

endpackage

// ===== rtl/core/f2h_stream_if.sv =====
// ----------------------------------------------------------------------------
// f2h_stream_if: valid/ready channel with a generic payload.
// Used for both the input and the result channel of the converter.
// ----------------------------------------------------------------------------
interface f2h_stream_if #(parameter int unsigned W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/fp32_to_fp20_convert.sv =====
// ----------------------------------------------------------------------------
// fp32_to_fp20_convert: binary32 to 20-bit float converter.
// Rounds half-up, flushes tiny values to zero and saturates large ones.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel carries single_bits (32 bits), one request per value.
// The out_ch channel carries {half20_bits, overflowed, underflowed}.
// An input request is registered on acceptance; the conversion logic sits
// between that register and the result register, which takes the result
// once it is empty or being emptied and drives out_ch.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single pass through the shift, round-increment and compare logic.
// When the receiver stalls, the result register holds and a full input
// register stays full; a new request is still taken whenever the input register
// is empty or the result register is empty or is being emptied in the same cycle.
// Reset clears both valid flags; no requests are in flight afterwards.
// ----------------------------------------------------------------------------
module fp32_to_fp20_convert
    import f2h_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    f2h_stream_if.sink          in_ch,
    f2h_stream_if.source        out_ch
);

    logic [IN_W-1:0] in_reg;
    logic            in_vld_reg;
    result_t         res_reg;
    logic            res_vld_reg;

    logic    res_load;
    logic    in_load;
    result_t res_next;

    assign res_load     = in_vld_reg && (!res_vld_reg || out_ch.ready);
    assign in_ch.ready  = !in_vld_reg || res_load;
    assign in_load      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = res_vld_reg;
    assign out_ch.data  = res_reg;

    // Conversion datapath.
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] f;
    logic [3:0]  shift;
    logic [23:0] sig;
    logic [18:0] mag;

    always_comb
    begin
        sgn   = in_reg[31];
        e     = in_reg[30:23];
        f     = in_reg[22:0];
        shift = 4'(EXP_NORMAL_FROM - e);
        sig   = {1'b1, f} >> shift;
        if (e >= EXP_NORMAL_FROM)
        begin
            mag = {6'(e - EXP_OFFSET), f[22:10]} + 19'(f[9]);
        end
        else
        begin
            mag = 19'(sig[23:10]) + 19'(sig[9]);
        end
        res_next = '0;
        if (e < EXP_FLUSH_BELOW)
        begin
            res_next.underflowed = 1'b1;
        end
        else if (e >= EXP_SAT_FROM || mag >= MAG_LIMIT)
        begin
            res_next.half20_bits = {sgn, OUT_EXP_MAX, OUT_MANT_ONES};
            res_next.overflowed  = 1'b1;
        end
        else
        begin
            res_next.half20_bits = {sgn, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (res_load)
            begin
                in_vld_reg <= 1'b0;
            end
            if (res_load)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= in_ch.data;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // The two flags never rise together.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> !(res_reg.overflowed && res_reg.underflowed))
        else $error("overflow and underflow both set");
    // Underflow always gives positive zero.
    a_unf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_reg.underflowed) |-> (res_reg.half20_bits == '0))
        else $error("underflow result not zero");
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !out_ch.ready) |=> (res_vld_reg && $stable(res_reg)))
        else $error("stalled result changed");
    // A full input stage moves to the result stage when that stage frees up.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && (!res_vld_reg || out_ch.ready)) |=> res_vld_reg)
        else $error("input stage did not advance");
`endif

endmodule
